>>> design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> design/dllm_pkg.sv
// Types and constants shared by the linked list manager modules.
package dllm_pkg;

    localparam int REQ_W    = 2;
    localparam int NODE_W   = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ATTACH_HEAD = 2'd0,
        REQ_ATTACH_TAIL = 2'd1,
        REQ_DETACH_HEAD = 2'd2,
        REQ_DETACH_NODE = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_NOT_IN_LIST = 2'd2,
        ST_ATTACHED    = 2'd3
    } status_t;

    typedef enum logic {
        STATE_IDLE = 1'b0,
        STATE_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dllm_cmd_t;

    typedef struct packed {
        logic out_full;
    } dllm_stat_t;

endpackage

>>> design/dllm_ctrl.sv
// Request sequencer: link read on transfer, update and result once output is free.
module dllm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_ready,
    input  dllm_pkg::dllm_stat_t  stat,
    output logic                  in_ready,
    output dllm_pkg::dllm_cmd_t   cmd
);
    import dllm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            STATE_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = STATE_EXEC;
                end
            end
            STATE_EXEC:
            begin
                // The result register must be free, or be emptied this cycle.
                cmd.commit = !stat.out_full || out_ready;
                if (cmd.commit)
                begin
                    state_next = STATE_IDLE;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

endmodule

>>> design/dllm_dpath.sv
// Head and tail registers, link memories and the result register.
module dllm_dpath #(
    parameter int POOL_NODES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dllm_pkg::dllm_cmd_t               cmd,
    output dllm_pkg::dllm_stat_t              stat,
    input  logic [dllm_pkg::REQ_W-1:0]        req_type,
    input  logic [dllm_pkg::NODE_W-1:0]       node_index,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [dllm_pkg::NODE_W-1:0]       result_node,
    output logic [dllm_pkg::STATUS_W-1:0]     status,
    output logic                              list_empty
);
    import dllm_pkg::*;

    // Only nodes that the request field can name ever enter the list.
    localparam int NODE_SPAN   = 1 << NODE_W;
    localparam int STORE_NODES = (POOL_NODES < NODE_SPAN) ? POOL_NODES : NODE_SPAN;
    localparam int LINK_W      = $clog2(STORE_NODES);
    localparam int DEPTH       = 1 << LINK_W;

    // List ends.
    logic              head_v_reg, head_v_next;
    logic [LINK_W-1:0] head_idx_reg, head_idx_next;
    logic              tail_v_reg, tail_v_next;
    logic [LINK_W-1:0] tail_idx_reg, tail_idx_next;

    // Link valid bits and link index memories.
    logic              next_v_reg [DEPTH];
    logic              prev_v_reg [DEPTH];
    logic [LINK_W-1:0] next_mem   [DEPTH];
    logic [LINK_W-1:0] prev_mem   [DEPTH];
    logic [LINK_W-1:0] rd_next_reg;
    logic [LINK_W-1:0] rd_prev_reg;

    // Captured request.
    req_t              req_reg;
    logic [NODE_W-1:0] node_reg;
    logic [LINK_W-1:0] addr_reg;
    logic              in_pool_reg;
    logic [LINK_W-1:0] rd_addr;

    // Result register.
    logic                out_valid_reg;
    logic [NODE_W-1:0]   result_node_reg;
    status_t             status_reg;
    logic                list_empty_reg;

    // Update controls computed in the execute cycle.
    logic              nx_we, nx_wv, pv_we, pv_wv;
    logic [LINK_W-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;
    logic              nx_clr, pv_clr;
    logic              do_unlink;
    logic              cur_nv, cur_pv, attached;
    logic [NODE_W-1:0] res_node;
    status_t           res_status;

    assign rd_addr = (req_t'(req_type) == REQ_DETACH_HEAD) ? head_idx_reg
                                                           : node_index[LINK_W-1:0];

    assign cur_nv   = next_v_reg[addr_reg];
    assign cur_pv   = prev_v_reg[addr_reg];
    assign attached = cur_nv || cur_pv || (head_v_reg && (head_idx_reg == addr_reg));

    always_comb
    begin
        head_v_next   = head_v_reg;
        head_idx_next = head_idx_reg;
        tail_v_next   = tail_v_reg;
        tail_idx_next = tail_idx_reg;
        nx_we = 1'b0; nx_wv = 1'b0; nx_waddr = addr_reg; nx_wdata = addr_reg;
        pv_we = 1'b0; pv_wv = 1'b0; pv_waddr = addr_reg; pv_wdata = addr_reg;
        nx_clr     = 1'b0;
        pv_clr     = 1'b0;
        do_unlink  = 1'b0;
        res_node   = node_reg;
        res_status = ST_OK;
        unique case (req_reg)
            REQ_ATTACH_HEAD:
            begin
                if (!in_pool_reg)
                begin
                    res_status = ST_NOT_IN_LIST;
                end
                else if (attached)
                begin
                    res_status = ST_ATTACHED;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = addr_reg;
                    nx_wv    = head_v_reg;
                    nx_wdata = head_idx_reg;
                    pv_clr   = 1'b1;
                    if (head_v_reg)
                    begin
                        pv_we    = 1'b1;
                        pv_waddr = head_idx_reg;
                        pv_wv    = 1'b1;
                        pv_wdata = addr_reg;
                    end
                    else
                    begin
                        tail_v_next   = 1'b1;
                        tail_idx_next = addr_reg;
                    end
                    head_v_next   = 1'b1;
                    head_idx_next = addr_reg;
                end
            end
            REQ_ATTACH_TAIL:
            begin
                if (!in_pool_reg)
                begin
                    res_status = ST_NOT_IN_LIST;
                end
                else if (attached)
                begin
                    res_status = ST_ATTACHED;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = addr_reg;
                    pv_wv    = tail_v_reg;
                    pv_wdata = tail_idx_reg;
                    nx_clr   = 1'b1;
                    if (tail_v_reg)
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = tail_idx_reg;
                        nx_wv    = 1'b1;
                        nx_wdata = addr_reg;
                    end
                    else
                    begin
                        head_v_next   = 1'b1;
                        head_idx_next = addr_reg;
                    end
                    tail_v_next   = 1'b1;
                    tail_idx_next = addr_reg;
                end
            end
            REQ_DETACH_HEAD:
            begin
                if (!head_v_reg)
                begin
                    res_status = ST_EMPTY;
                    res_node   = '0;
                end
                else
                begin
                    res_node  = NODE_W'(head_idx_reg);
                    do_unlink = 1'b1;
                end
            end
            REQ_DETACH_NODE:
            begin
                if (!head_v_reg)
                begin
                    res_status = ST_EMPTY;
                end
                else if (!in_pool_reg)
                begin
                    res_status = ST_NOT_IN_LIST;
                end
                else if (!cur_pv && (head_idx_reg != addr_reg))
                begin
                    res_status = ST_NOT_IN_LIST;
                end
                else
                begin
                    do_unlink = 1'b1;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase

        if (do_unlink)
        begin
            // Splice the neighbors together and leave the node with null links.
            nx_clr = 1'b1;
            pv_clr = 1'b1;
            if (cur_nv)
            begin
                pv_we    = 1'b1;
                pv_waddr = rd_next_reg;
                pv_wv    = cur_pv;
                pv_wdata = rd_prev_reg;
            end
            else
            begin
                tail_v_next   = cur_pv;
                tail_idx_next = rd_prev_reg;
            end
            if (cur_pv)
            begin
                nx_we    = 1'b1;
                nx_waddr = rd_prev_reg;
                nx_wv    = cur_nv;
                nx_wdata = rd_next_reg;
            end
            else
            begin
                head_v_next   = cur_nv;
                head_idx_next = rd_next_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg    <= 1'b0;
            tail_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                next_v_reg[i] <= 1'b0;
                prev_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.commit)
            begin
                head_v_reg <= head_v_next;
                tail_v_reg <= tail_v_next;
                if (nx_clr)
                begin
                    next_v_reg[addr_reg] <= 1'b0;
                end
                if (nx_we)
                begin
                    next_v_reg[nx_waddr] <= nx_wv;
                end
                if (pv_clr)
                begin
                    prev_v_reg[addr_reg] <= 1'b0;
                end
                if (pv_we)
                begin
                    prev_v_reg[pv_waddr] <= pv_wv;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg     <= req_t'(req_type);
            node_reg    <= node_index;
            addr_reg    <= rd_addr;
            in_pool_reg <= (int'(node_index) < POOL_NODES);
        end
        if (cmd.commit)
        begin
            head_idx_reg    <= head_idx_next;
            tail_idx_reg    <= tail_idx_next;
            result_node_reg <= res_node;
            status_reg      <= res_status;
            list_empty_reg  <= !head_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_next_reg <= next_mem[rd_addr];
        end
        if (cmd.commit && nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_prev_reg <= prev_mem[rd_addr];
        end
        if (cmd.commit && pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
    end

    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign result_node   = result_node_reg;
    assign status        = status_reg;
    assign list_empty    = list_empty_reg;

endmodule

>>> design/doubly_linked_list_manager.sv
// Top level of the doubly linked list manager: sequencer plus link datapath.
//
// Usage: the input channel (in_valid/in_ready) carries one request per transfer,
// req_type and node_index. Each request gives exactly one result transfer on the
// output channel (out_valid/out_ready): result_node, status and list_empty.
// A request runs in a read step and an update step: on the input transfer the node's next
// and previous links are read from the link memories; in the execute state, once the result
// register is free, the neighbor links and the head and tail registers are updated and the result register is loaded.
// The result is registered: out_valid rises after the update step has loaded the result
// register. A new request is not taken while one is still in its update step, as each
// request makes a single read-then-write pass through the link memories.
// The input channel is ready again as soon as the result is loaded, so a request
// may be accepted while the previous result is still waiting to be taken. If the
// receiver stalls, the second request waits in its update cycle until the result
// register is emptied, and in_ready stays low meanwhile.
// Reset clears the head and tail valid bits and every link valid bit, so the list
// starts empty; the block accepts requests in the first cycle after reset.
module doubly_linked_list_manager #(
    parameter int POOL_NODES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dllm_pkg::REQ_W-1:0]        req_type,
    input  logic [dllm_pkg::NODE_W-1:0]       node_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dllm_pkg::NODE_W-1:0]       result_node,
    output logic [dllm_pkg::STATUS_W-1:0]     status,
    output logic                              list_empty
);
    import dllm_pkg::*;

    `include "assert_macros.svh"

    dllm_cmd_t  cmd;
    dllm_stat_t stat;

    // The sequencer owns the handshake timing; the datapath owns the list state and the result register.
    dllm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    dllm_dpath #(
        .POOL_NODES (POOL_NODES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .node_index  (node_index),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .result_node (result_node),
        .status      (status),
        .list_empty  (list_empty)
    );

    // A request is never captured and committed in the same cycle.
    `ASSERT_SAME(a_no_capture_commit, clk, rst_n, cmd.capture, !cmd.commit)
    // After a request is captured the block is busy with its update cycle.
    `ASSERT_NEXT(a_busy_after_capture, clk, rst_n, cmd.capture, !in_ready)
    // Every committed request shows a result in the next cycle.
    `ASSERT_NEXT(a_commit_gives_result, clk, rst_n, cmd.commit, out_valid)
    // A result taken with no new commit leaves the result register empty.
    `ASSERT_NEXT(a_drain_empties, clk, rst_n,
        out_valid && out_ready && !cmd.commit, !out_valid)

endmodule

>>> bench/tb.sv
// Self-checking testbench for the doubly linked list manager.
`timescale 1ns / 100ps

module tb;

    import dllm_pkg::*;

    localparam int POOL_NODES    = 16;
    localparam int RANDOM_ITEMS  = 700;
    localparam int SETTLE_CYCLES = 10;

    // One result as the block should report it.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        status_t           stat;
        logic              empty;
    } list_result_t;

    // One directed row. Rows with typed set carry an expected result that can be
    // read straight off the request; the others are checked against the predictor.
    typedef struct packed {
        req_t              req;
        logic [NODE_W-1:0] node;
        logic              typed;
        logic [NODE_W-1:0] x_node;
        status_t           x_stat;
        logic              x_empty;
    } stim_row_t;

    localparam int NUM_ROWS = 23;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Detach requests on the empty list right after reset.
        '{REQ_DETACH_HEAD, 4'd0,  1'b1, 4'd0,  ST_EMPTY,       1'b1},
        '{REQ_DETACH_NODE, 4'd15, 1'b1, 4'd15, ST_EMPTY,       1'b1},
        // First node at each end, then attaching them again from either side.
        '{REQ_ATTACH_HEAD, 4'd0,  1'b1, 4'd0,  ST_OK,          1'b0},
        '{REQ_ATTACH_HEAD, 4'd0,  1'b1, 4'd0,  ST_ATTACHED,    1'b0},
        '{REQ_ATTACH_TAIL, 4'd15, 1'b1, 4'd15, ST_OK,          1'b0},
        '{REQ_ATTACH_TAIL, 4'd15, 1'b1, 4'd15, ST_ATTACHED,    1'b0},
        '{REQ_ATTACH_HEAD, 4'd15, 1'b1, 4'd15, ST_ATTACHED,    1'b0},
        // A node that was never attached cannot be detached.
        '{REQ_DETACH_NODE, 4'd7,  1'b1, 4'd7,  ST_NOT_IN_LIST, 1'b0},
        '{REQ_ATTACH_TAIL, 4'd7,  1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_ATTACH_HEAD, 4'd10, 1'b0, 4'd0,  ST_OK,          1'b0},
        // Detach from the middle, the tail and the head of the list.
        '{REQ_DETACH_NODE, 4'd15, 1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_DETACH_NODE, 4'd7,  1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_DETACH_NODE, 4'd10, 1'b0, 4'd0,  ST_OK,          1'b0},
        // Removing the last node empties the list; doing it again finds it empty.
        '{REQ_DETACH_NODE, 4'd0,  1'b1, 4'd0,  ST_OK,          1'b1},
        '{REQ_DETACH_NODE, 4'd0,  1'b1, 4'd0,  ST_EMPTY,       1'b1},
        // Build three nodes and pop them all from the head.
        '{REQ_ATTACH_TAIL, 4'd5,  1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_ATTACH_TAIL, 4'd9,  1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_ATTACH_HEAD, 4'd3,  1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_DETACH_HEAD, 4'd12, 1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_DETACH_HEAD, 4'd0,  1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_DETACH_HEAD, 4'd6,  1'b0, 4'd0,  ST_OK,          1'b0},
        '{REQ_DETACH_HEAD, 4'd0,  1'b1, 4'd0,  ST_EMPTY,       1'b1},
        '{REQ_DETACH_NODE, 4'd5,  1'b1, 4'd5,  ST_EMPTY,       1'b1}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type;
    logic [NODE_W-1:0]   node_index;
    logic                out_valid;
    logic                out_ready;
    logic [NODE_W-1:0]   result_node;
    logic [STATUS_W-1:0] status;
    logic                list_empty;

    // Shadow copy of the list: head and tail registers plus per-node links,
    // each with a valid bit.
    logic                head_v;
    logic [NODE_W-1:0]   head_idx;
    logic                tail_v;
    logic [NODE_W-1:0]   tail_idx;
    logic                succ_v   [POOL_NODES];
    logic [NODE_W-1:0]   succ_idx [POOL_NODES];
    logic                pred_v   [POOL_NODES];
    logic [NODE_W-1:0]   pred_idx [POOL_NODES];
    int                  list_len;

    list_result_t        pending_results [$];
    int                  error_count;
    // When set, neither side inserts idle cycles.
    bit                  quiet;

    doubly_linked_list_manager #(
        .POOL_NODES (POOL_NODES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .node_index  (node_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_node (result_node),
        .status      (status),
        .list_empty  (list_empty)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report_error(input string msg);
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            error_count++;
        end
    endtask

    function automatic void clear_list();
        begin
            head_v   = 1'b0;
            head_idx = '0;
            tail_v   = 1'b0;
            tail_idx = '0;
            list_len = 0;
            for (int i = 0; i < POOL_NODES; i++)
            begin
                succ_v[i]   = 1'b0;
                succ_idx[i] = '0;
                pred_v[i]   = 1'b0;
                pred_idx[i] = '0;
            end
        end
    endfunction

    // A node counts as attached when it has either link or is the head.
    function automatic logic node_attached(input logic [NODE_W-1:0] n);
        begin
            return succ_v[n] || pred_v[n] || (head_v && head_idx == n);
        end
    endfunction

    // Splices node n out of the shadow list and nulls its own links.
    function automatic void unlink_node(input logic [NODE_W-1:0] n);
        logic              nx_v;
        logic [NODE_W-1:0] nx;
        logic              pv_v;
        logic [NODE_W-1:0] pv;
        begin
            nx_v = succ_v[n];
            nx   = succ_idx[n];
            pv_v = pred_v[n];
            pv   = pred_idx[n];
            if (nx_v)
            begin
                pred_v[nx]   = pv_v;
                pred_idx[nx] = pv;
            end
            else
            begin
                tail_v   = pv_v;
                tail_idx = pv;
            end
            if (pv_v)
            begin
                succ_v[pv]   = nx_v;
                succ_idx[pv] = nx;
            end
            else
            begin
                head_v   = nx_v;
                head_idx = nx;
            end
            succ_v[n]   = 1'b0;
            succ_idx[n] = '0;
            pred_v[n]   = 1'b0;
            pred_idx[n] = '0;
            list_len--;
        end
    endfunction

    // Applies one request to the shadow list and returns the result it should give.
    function automatic list_result_t apply_request(input req_t r,
                                                   input logic [NODE_W-1:0] n);
        list_result_t res;
        begin
            res.node = n;
            res.stat = ST_OK;
            case (r)
                REQ_ATTACH_HEAD, REQ_ATTACH_TAIL:
                begin
                    if (node_attached(n))
                        res.stat = ST_ATTACHED;
                    else if (r == REQ_ATTACH_HEAD)
                    begin
                        succ_v[n]   = head_v;
                        succ_idx[n] = head_idx;
                        pred_v[n]   = 1'b0;
                        pred_idx[n] = '0;
                        if (head_v)
                        begin
                            pred_v[head_idx]   = 1'b1;
                            pred_idx[head_idx] = n;
                        end
                        else
                        begin
                            tail_v   = 1'b1;
                            tail_idx = n;
                        end
                        head_v   = 1'b1;
                        head_idx = n;
                        list_len++;
                    end
                    else
                    begin
                        pred_v[n]   = tail_v;
                        pred_idx[n] = tail_idx;
                        succ_v[n]   = 1'b0;
                        succ_idx[n] = '0;
                        if (tail_v)
                        begin
                            succ_v[tail_idx]   = 1'b1;
                            succ_idx[tail_idx] = n;
                        end
                        else
                        begin
                            head_v   = 1'b1;
                            head_idx = n;
                        end
                        tail_v   = 1'b1;
                        tail_idx = n;
                        list_len++;
                    end
                end
                REQ_DETACH_HEAD:
                begin
                    if (!head_v)
                    begin
                        res.stat = ST_EMPTY;
                        res.node = '0;
                    end
                    else
                    begin
                        res.node = head_idx;
                        unlink_node(head_idx);
                    end
                end
                default:
                begin
                    if (!head_v)
                        res.stat = ST_EMPTY;
                    else if (!pred_v[n] && head_idx != n)
                        res.stat = ST_NOT_IN_LIST;
                    else
                        unlink_node(n);
                end
            endcase
            res.empty = !head_v;
            return res;
        end
    endfunction

    // Offers one request after a random gap and waits for its transfer. The
    // predictor is applied at the accepting edge so it stays in request order.
    task automatic send_request(input req_t r, input logic [NODE_W-1:0] n,
                                output list_result_t predicted);
        int gap;
        begin
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid   <= 1'b1;
            req_type   <= r;
            node_index <= n;
            do
                @(posedge clk);
            while (!in_ready);
            predicted = apply_request(r, n);
        end
    endtask

    // Picks a random node that is (want_attached = 1) or is not in the list,
    // falling back to any node when none qualifies.
    function automatic logic [NODE_W-1:0] pick_node(input bit want_attached);
        int start;
        logic [NODE_W-1:0] cand;
        begin
            start = $urandom_range(0, POOL_NODES - 1);
            for (int k = 0; k < POOL_NODES; k++)
            begin
                cand = NODE_W'((start + k) % POOL_NODES);
                if (node_attached(cand) == want_attached)
                    return cand;
            end
            return NODE_W'(start);
        end
    endfunction

    // Receiver: stalls at random, then checks every result transfer against the
    // oldest expected result.
    initial
    begin
        list_result_t want;
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_results.size() == 0)
                report_error($sformatf("result node %0d status %0d with nothing expected",
                                       result_node, status));
            else
            begin
                want = pending_results.pop_front();
                if (result_node !== want.node)
                    report_error($sformatf("result_node got %0d expected %0d",
                                           result_node, want.node));
                if (status !== want.stat)
                    report_error($sformatf("status got %0d expected %0d",
                                           status, want.stat));
                if (list_empty !== want.empty)
                    report_error($sformatf("list_empty got %0d expected %0d",
                                           list_empty, want.empty));
            end
        end
    end

    // Stimulus: directed table first, then random requests in alternating
    // growing and shrinking phases.
    initial
    begin
        list_result_t predicted;
        stim_row_t row;
        req_t r;
        logic [NODE_W-1:0] n;
        bit filling;
        int pick;
        error_count = 0;
        quiet       = 1'b0;
        filling     = 1'b1;
        clear_list();
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_ATTACH_HEAD;
        node_index <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            send_request(row.req, row.node, predicted);
            if (row.typed)
                pending_results.push_back('{node: row.x_node, stat: row.x_stat,
                                            empty: row.x_empty});
            else
                pending_results.push_back(predicted);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i % 48 == 0)
                filling = (list_len < POOL_NODES / 2) ? 1'b1 : !filling;
            pick = $urandom_range(0, 99);
            if (pick < (filling ? 70 : 25))
            begin
                r = ($urandom_range(0, 1) == 0) ? REQ_ATTACH_HEAD : REQ_ATTACH_TAIL;
                // Mostly free nodes; the rest are random and may hit the already-attached case.
                n = ($urandom_range(0, 4) != 0) ? pick_node(1'b0)
                                                : NODE_W'($urandom_range(0, 15));
            end
            else if (pick < (filling ? 80 : 55))
            begin
                r = REQ_DETACH_HEAD;
                n = NODE_W'($urandom_range(0, 15));
            end
            else
            begin
                r = REQ_DETACH_NODE;
                n = ($urandom_range(0, 3) != 0) ? pick_node(1'b1)
                                                : NODE_W'($urandom_range(0, 15));
            end
            send_request(r, n, predicted);
            pending_results.push_back(predicted);
        end
        in_valid <= 1'b0;

        // Drain: every expected result must arrive, then a short settle.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/dllm_pkg.sv
design/dllm_ctrl.sv
design/dllm_dpath.sv
design/doubly_linked_list_manager.sv
bench/tb.sv
